### src/mcs_pkg.sv
package mcs_pkg;

	// accumulator datapath, worked one digit per cycle
	localparam int ACC_W     = 40;
	localparam int DIGIT_W   = 4;
	localparam int NDIG      = ACC_W / DIGIT_W;
	localparam int DIG_CNT_W = $clog2(NDIG);

	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// restoring divider for the distance increment
	localparam int DIV_W     = 28;
	localparam int REM_W     = 10;
	localparam int DIVISOR   = 1000;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// action codes on the result
	localparam logic [1:0] ACT_TURN  = 2'd0;
	localparam logic [1:0] ACT_DRIVE = 2'd1;
	localparam logic [1:0] ACT_NEXT  = 2'd2;
	localparam logic [1:0] ACT_DONE  = 2'd3;

	typedef struct packed {
		logic             start;
		logic             sub;
		logic [ACC_W-1:0] addend;
	} add_req_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
	} div_req_t;

endpackage

### src/mcs_ser_acc.sv
// Saturating 40-bit accumulator, one digit per cycle, LSB digit first.
module mcs_ser_acc import mcs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  add_req_t         req,
	output logic             busy,
	output logic [ACC_W-1:0] acc
);

	logic [ACC_W-1:0]     acc_q;
	logic [ACC_W-1:0]     add_q;
	logic                 carry_q;
	logic                 busy_q;
	logic                 sa_q;
	logic                 sb_q;
	logic [DIG_CNT_W-1:0] dig_q;

	logic [ACC_W-1:0]   add_eff;
	logic [DIGIT_W:0]   dsum;
	logic [ACC_W-1:0]   acc_shift;
	logic               ovf;

	assign add_eff   = req.sub ? ~req.addend : req.addend;
	assign dsum      = {1'b0, acc_q[DIGIT_W-1:0]} + {1'b0, add_q[DIGIT_W-1:0]}
		+ {{DIGIT_W{1'b0}}, carry_q};
	assign acc_shift = {dsum[DIGIT_W-1:0], acc_q[ACC_W-1:DIGIT_W]};
	// signed overflow: like-signed operands, result sign differs
	assign ovf       = (sa_q == sb_q) && (dsum[DIGIT_W-1] != sa_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			busy_q  <= 1'b0;
			carry_q <= 1'b0;
			dig_q   <= '0;
		end else if (busy_q) begin
			add_q   <= add_q >> DIGIT_W;
			carry_q <= dsum[DIGIT_W];
			dig_q   <= dig_q + 1'b1;
			if (dig_q == DIG_CNT_W'(NDIG - 1)) begin
				busy_q <= 1'b0;
				acc_q  <= ovf ? (sa_q ? ACC_MIN : ACC_MAX) : acc_shift;
			end else begin
				acc_q <= acc_shift;
			end
		end else if (req.start) begin
			add_q   <= add_eff;
			carry_q <= req.sub;
			sa_q    <= acc_q[ACC_W-1];
			sb_q    <= add_eff[ACC_W-1];
			dig_q   <= '0;
			busy_q  <= 1'b1;
		end
	end

	assign busy = busy_q;
	assign acc  = acc_q;

endmodule

### src/mcs_div_k.sv
// Bit-serial restoring division by a constant; quotient shifts into the dividend.
module mcs_div_k import mcs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output logic             busy,
	output logic [DIV_W-1:0] quot
);

	logic [DIV_W-1:0]     dvd_q;
	logic [REM_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;

	logic [REM_W:0]   trial;
	logic             ge;
	logic [REM_W-1:0] rem_d;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign ge    = trial >= (REM_W+1)'(DIVISOR);
	assign rem_d = ge ? REM_W'(trial - (REM_W+1)'(DIVISOR)) : trial[REM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			rem_q <= rem_d;
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_W - 1))
				busy_q <= 1'b0;
		end else if (req.start) begin
			dvd_q  <= req.dividend;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end
	end

	assign busy = busy_q;
	assign quot = dvd_q;

endmodule

### src/motion_command_sequencer_core.sv
// Each accumulator pass that a tick does not need (distance increment, step) is skipped.
// One tick at a time; in_ready returns only when the result is loaded.
// Reset (arst_n low): accumulators, last speeds and pointer clear, registers
//   take their defaults, no result pending.
module motion_command_sequencer_core import mcs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// tick input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] gyro_z,
	input  logic [9:0]         elapsed_ms,
	input  logic [9:0]         battery_level,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         pwm_a,
	output logic               reverse_a,
	output logic [7:0]         pwm_b,
	output logic               reverse_b,
	output logic               standby_on,
	output logic [1:0]         action,
	output logic [3:0]         step_number,
	// register write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [29:0]        cfg_data
);

	// register map
	localparam logic [2:0] REG_YAW_THR   = 3'd0;
	localparam logic [2:0] REG_DIST_THR  = 3'd1;
	localparam logic [2:0] REG_STEP      = 3'd2;
	localparam logic [2:0] REG_SPEED     = 3'd3;
	localparam logic [2:0] REG_GYRO_OFF  = 3'd4;
	localparam logic [2:0] REG_CMD_LIST  = 3'd5;
	localparam logic [2:0] REG_CMD_COUNT = 3'd6;

	// command codes
	localparam logic [2:0] CMD_STOP  = 3'd0;
	localparam logic [2:0] CMD_FWD   = 3'd1;
	localparam logic [2:0] CMD_BACK  = 3'd2;
	localparam logic [2:0] CMD_RIGHT = 3'd3;
	localparam logic [2:0] CMD_LEFT  = 3'd4;

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MUL1   = 4'd1;
	localparam logic [3:0] S_MUL2   = 4'd2;
	localparam logic [3:0] S_DIV    = 4'd3;
	localparam logic [3:0] S_DECIDE = 4'd4;
	localparam logic [3:0] S_ADD1   = 4'd5;
	localparam logic [3:0] S_WAIT1  = 4'd6;
	localparam logic [3:0] S_ADD2   = 4'd7;
	localparam logic [3:0] S_WAIT2  = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;

	localparam int RATE_W = 17;          // gyro minus offset
	localparam int PY_W   = 27;          // rate * ms
	localparam int MS_W   = 10;
	localparam int MSB_W  = 20;          // ms * battery
	localparam int MAG_W  = 8;           // speed magnitude

	localparam logic [3:0]       MAX_COMMANDS = 4'd8;
	localparam logic [ACC_W-1:0] QUARTER_TURN = ACC_W'(11790000);

	// ---------------- configuration registers ----------------
	logic [29:0]        yaw_thr_q;
	logic [29:0]        dist_thr_q;
	logic [29:0]        step_q;
	logic [7:0]         speed_q;
	logic signed [15:0] gyro_off_q;
	logic [23:0]        cmd_list_q;
	logic [3:0]         cmd_count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_thr_q   <= 30'd393000;
			dist_thr_q  <= 30'd500;
			step_q      <= 30'd1000000;
			speed_q     <= 8'd100;
			gyro_off_q  <= 16'sd0;
			cmd_list_q  <= 24'd6233;
			cmd_count_q <= 4'd6;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_YAW_THR:   yaw_thr_q   <= cfg_data;
				REG_DIST_THR:  dist_thr_q  <= cfg_data;
				REG_STEP:      step_q      <= cfg_data;
				REG_SPEED:     speed_q     <= cfg_data[7:0];
				REG_GYRO_OFF:  gyro_off_q  <= cfg_data[15:0];
				REG_CMD_LIST:  cmd_list_q  <= cfg_data[23:0];
				REG_CMD_COUNT: cmd_count_q <= cfg_data[3:0];
				default: ;    // index past the map is dropped
			endcase
		end
	end

	// ---------------- sequencer state ----------------
	logic [3:0]       state_q;
	logic [3:0]       cnt_q;

	// shift-add multipliers: multiplier bits leave LSB first, one per cycle
	logic [PY_W-1:0]  pyaw_q;
	logic [PY_W-1:0]  ycand_q;
	logic [MSB_W-1:0] msb_q;
	logic [MSB_W-1:0] bcand_q;
	logic [MS_W-1:0]  mlt_q;
	logic [DIV_W-1:0] t_q;
	logic [DIV_W-1:0] tcand_q;
	logic [MAG_W-1:0] tmul_q;

	// previous motor speeds: both carry the same magnitude
	logic [MAG_W-1:0] last_mag_q;
	logic             last_rev_a_q;
	logic             last_rev_b_q;
	logic [3:0]       ptr_q;

	// decision of this tick
	logic [MAG_W-1:0] dec_mag_q;
	logic             dec_rev_a_q;
	logic             dec_rev_b_q;
	logic [1:0]       dec_act_q;
	logic [2:0]       cmd_q;

	// result register
	logic             out_valid_q;
	logic [7:0]       pwm_a_q;
	logic             reverse_a_q;
	logic [7:0]       pwm_b_q;
	logic             reverse_b_q;
	logic             standby_q;
	logic [1:0]       action_q;
	logic [3:0]       step_q_out_q;

	// ---------------- serial units ----------------
	add_req_t         yaw_req;
	add_req_t         dist_req;
	div_req_t         div_req;
	logic             yaw_busy;
	logic             dist_busy;
	logic             div_busy;
	logic [ACC_W-1:0] yaw_acc;
	logic [ACC_W-1:0] dist_acc;
	logic [DIV_W-1:0] quot;

	mcs_ser_acc u_yaw (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (yaw_req),
		.busy   (yaw_busy),
		.acc    (yaw_acc)
	);

	mcs_ser_acc u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dist_req),
		.busy   (dist_busy),
		.acc    (dist_acc)
	);

	mcs_div_k u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.quot   (quot)
	);

	// ---------------- datapath next values ----------------
	logic [RATE_W-1:0] rate;
	logic [PY_W-1:0]   pyaw_d;
	logic [MSB_W-1:0]  msb_d;
	logic [DIV_W-1:0]  t_d;

	assign rate   = {gyro_z[15], gyro_z} - {gyro_off_q[15], gyro_off_q};
	assign pyaw_d = mlt_q[0] ? pyaw_q + ycand_q : pyaw_q;
	assign msb_d  = mlt_q[0] ? msb_q + bcand_q : msb_q;
	assign t_d    = tmul_q[0] ? t_q + tcand_q : t_q;

	// heading / distance tests: for a negative value, v < -thr is ~v >= thr
	logic [ACC_W-1:0] yaw_thr_ext;
	logic [ACC_W-1:0] dist_thr_ext;
	logic             yaw_neg;
	logic             dist_neg;
	logic             yaw_big;
	logic             dist_big;
	logic [3:0]       limit;
	logic             at_end;
	logic [2:0]       cmd_w;

	assign yaw_thr_ext  = {{(ACC_W-30){1'b0}}, yaw_thr_q};
	assign dist_thr_ext = {{(ACC_W-30){1'b0}}, dist_thr_q};
	assign yaw_neg      = yaw_acc[ACC_W-1];
	assign dist_neg     = dist_acc[ACC_W-1];
	assign yaw_big      = yaw_neg ? (~yaw_acc >= yaw_thr_ext) : (yaw_acc > yaw_thr_ext);
	assign dist_big     = dist_neg ? (~dist_acc >= dist_thr_ext) : (dist_acc > dist_thr_ext);
	assign limit        = (cmd_count_q > MAX_COMMANDS) ? MAX_COMMANDS : cmd_count_q;
	assign at_end       = ptr_q >= limit;
	assign cmd_w        = 3'(cmd_list_q >> ({2'b00, ptr_q[2:0]} * 5'd3));

	// ---------------- unit requests ----------------
	always_comb begin
		yaw_req = '0;
		if (state_q == S_MUL2 && cnt_q == 4'd0) begin
			// integrate the rate term once the product is complete
			yaw_req.start  = 1'b1;
			yaw_req.addend = {{(ACC_W-PY_W){pyaw_q[PY_W-1]}}, pyaw_q};
		end else if (state_q == S_ADD1 && (cmd_q == CMD_RIGHT || cmd_q == CMD_LEFT)) begin
			yaw_req.start  = 1'b1;
			yaw_req.sub    = (cmd_q == CMD_LEFT);
			yaw_req.addend = QUARTER_TURN;
		end
	end

	always_comb begin
		dist_req = '0;
		if (state_q == S_ADD1 && last_rev_a_q == last_rev_b_q) begin
			// odometry term uses the previous speeds; its sign is speed a's
			dist_req.start  = 1'b1;
			dist_req.sub    = last_rev_a_q;
			dist_req.addend = {{(ACC_W-DIV_W){1'b0}}, quot};
		end else if (state_q == S_ADD2 && (cmd_q == CMD_FWD || cmd_q == CMD_BACK)) begin
			dist_req.start  = 1'b1;
			dist_req.sub    = (cmd_q == CMD_FWD);
			dist_req.addend = {{(ACC_W-30){1'b0}}, step_q};
		end
	end

	assign div_req.start    = (state_q == S_MUL2) && (cnt_q == 4'(MAG_W - 1));
	assign div_req.dividend = t_d;

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			ptr_q        <= '0;
			last_mag_q   <= '0;
			last_rev_a_q <= 1'b0;
			last_rev_b_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ycand_q <= {{(PY_W-RATE_W){rate[RATE_W-1]}}, rate};
						bcand_q <= {{(MSB_W-10){1'b0}}, battery_level};
						mlt_q   <= elapsed_ms;
						pyaw_q  <= '0;
						msb_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					// yaw rate * ms and ms * battery share the multiplier bits
					pyaw_q  <= pyaw_d;
					msb_q   <= msb_d;
					ycand_q <= ycand_q << 1;
					bcand_q <= bcand_q << 1;
					mlt_q   <= mlt_q >> 1;
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == 4'(MS_W - 1)) begin
						tcand_q <= {{(DIV_W-MSB_W){1'b0}}, msb_d};
						tmul_q  <= last_mag_q;
						t_q     <= '0;
						cnt_q   <= '0;
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					// (ms * battery) * |previous speed|, divider starts on the last bit
					t_q     <= t_d;
					tcand_q <= tcand_q << 1;
					tmul_q  <= tmul_q >> 1;
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == 4'(MAG_W - 1))
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (!div_busy && !yaw_busy)
						state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					// heading first, then distance, else next command
					cmd_q <= CMD_STOP;
					if (yaw_big) begin
						dec_act_q   <= ACT_TURN;
						dec_mag_q   <= speed_q;
						dec_rev_a_q <= (speed_q != 8'd0) && !yaw_neg;
						dec_rev_b_q <= (speed_q != 8'd0) && yaw_neg;
					end else if (dist_big) begin
						dec_act_q   <= ACT_DRIVE;
						dec_mag_q   <= speed_q;
						dec_rev_a_q <= (speed_q != 8'd0) && !dist_neg;
						dec_rev_b_q <= (speed_q != 8'd0) && !dist_neg;
					end else begin
						dec_mag_q   <= '0;
						dec_rev_a_q <= 1'b0;
						dec_rev_b_q <= 1'b0;
						if (at_end) begin
							dec_act_q <= ACT_DONE;
						end else begin
							dec_act_q <= ACT_NEXT;
							// unused codes fall through as stop
							cmd_q     <= cmd_w;
							ptr_q     <= ptr_q + 1'b1;
						end
					end
					state_q <= S_ADD1;
				end
				S_ADD1: begin
					state_q <= S_WAIT1;
				end
				S_WAIT1: begin
					if (!dist_busy)
						state_q <= S_ADD2;
				end
				S_ADD2: begin
					state_q <= S_WAIT2;
				end
				S_WAIT2: begin
					if (!dist_busy && !yaw_busy)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						pwm_a_q      <= dec_mag_q;
						pwm_b_q      <= dec_mag_q;
						reverse_a_q  <= dec_rev_a_q;
						reverse_b_q  <= dec_rev_b_q;
						standby_q    <= (dec_mag_q != 8'd0);
						action_q     <= dec_act_q;
						step_q_out_q <= ptr_q;
						last_mag_q   <= dec_mag_q;
						last_rev_a_q <= dec_rev_a_q;
						last_rev_b_q <= dec_rev_b_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign pwm_a       = pwm_a_q;
	assign reverse_a   = reverse_a_q;
	assign pwm_b       = pwm_b_q;
	assign reverse_b   = reverse_b_q;
	assign standby_on  = standby_q;
	assign action      = action_q;
	assign step_number = step_q_out_q;

endmodule

### src/mcs_checker.sv
module mcs_checker import mcs_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [7:0]         pwm_a,
	input logic               reverse_a,
	input logic [7:0]         pwm_b,
	input logic               reverse_b,
	input logic               standby_on,
	input logic [1:0]         action,
	input logic [3:0]         step_number
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pwm_a) && $stable(action)
			&& $stable(step_number))
		else $error("result changed while stalled");

	// one tick in flight: an accepted transaction makes the block busy
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second tick accepted while busy");

	// both motors share one magnitude; enable follows it
	a_mag_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pwm_a == pwm_b) && (standby_on == (pwm_a != 8'd0)))
		else $error("motor magnitudes or enable inconsistent");

	// next and done results show neither a speed nor a reverse direction
	a_stop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_NEXT || action == ACT_DONE || pwm_a == 8'd0)
			|-> !reverse_a && !reverse_b && pwm_a == 8'd0 || action == ACT_TURN
			|| action == ACT_DRIVE)
		else $error("stopped result carries direction or speed");

	// command pointer never passes the eight-entry list limit
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> step_number <= 4'd8)
		else $error("step number out of range");

endmodule

bind motion_command_sequencer_core mcs_checker u_mcs_checker (.*);

### bench/tb_motion_command_sequencer_core.sv
module tb_motion_command_sequencer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import mcs_pkg::*;

	// register map of the write channel, in port order
	typedef enum logic [2:0] {
		REG_YAW_THR   = 3'd0,
		REG_DIST_THR  = 3'd1,
		REG_STEP_DIST = 3'd2,
		REG_SPEED     = 3'd3,
		REG_GYRO_OFS  = 3'd4,
		REG_CMD_LIST  = 3'd5,
		REG_CMD_COUNT = 3'd6
	} reg_idx_e;

	// command list entries; 5..7 are unused and behave like stop
	typedef enum logic [2:0] {
		CMD_STOP  = 3'd0,
		CMD_FWD   = 3'd1,
		CMD_BACK  = 3'd2,
		CMD_RIGHT = 3'd3,
		CMD_LEFT  = 3'd4
	} cmd_e;

	typedef struct packed {
		logic signed [15:0] gyro;
		logic [9:0]         ms;
		logic [9:0]         batt;
	} tick_t;

	// field order matches the concatenation of the result ports below
	typedef struct packed {
		logic [7:0] pwm_a;
		logic       reverse_a;
		logic [7:0] pwm_b;
		logic       reverse_b;
		logic       standby_on;
		logic [1:0] action;
		logic [3:0] step_number;
	} motor_result_t;

	localparam int     MAX_CMDS     = 8;
	localparam longint QUARTER_TURN = 64'sd11790000;   // 90 deg in 1/131000 deg
	localparam longint SAT_HI       = 64'sd549755813887;
	localparam longint SAT_LO       = -SAT_HI - 1;
	localparam int     STALL_CYCLES = 600;
	localparam int     TAIL_CYCLES  = 80;              // idle tail before the end of the run

	// DUT ports; every input starts at a known value
	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               in_valid      = 1'b0;
	logic               in_ready;
	logic signed [15:0] gyro_z        = '0;
	logic [9:0]         elapsed_ms    = '0;
	logic [9:0]         battery_level = '0;
	logic               out_valid;
	logic               out_ready     = 1'b0;
	logic [7:0]         pwm_a;
	logic               reverse_a;
	logic [7:0]         pwm_b;
	logic               reverse_b;
	logic               standby_on;
	logic [1:0]         action;
	logic [3:0]         step_number;
	logic               cfg_valid     = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index     = '0;
	logic [29:0]        cfg_data      = '0;

	// Predictor copy of the register file, starting at the reset defaults
	logic [29:0]        cfg_yaw_thr     = 30'd393000;
	logic [29:0]        cfg_dist_thr    = 30'd500;
	logic [29:0]        cfg_step_dist   = 30'd1000000;
	logic [7:0]         cfg_drive_speed = 8'd100;
	logic signed [15:0] cfg_gyro_offset = '0;
	logic [23:0]        cfg_cmd_list    = 24'd6233;    // fwd, right, fwd, left, fwd, stop
	logic [3:0]         cfg_cmd_count   = 4'd6;

	// Predictor copy of the sequencer state
	logic signed [39:0] yaw_acc  = '0;
	logic signed [39:0] dist_acc = '0;
	logic signed [8:0]  last_a   = '0;
	logic signed [8:0]  last_b   = '0;
	logic [3:0]         cmd_ptr  = '0;

	tick_t         pending_ticks[$];      // generated, not yet on the bus
	motor_result_t predicted_results[$];  // one per accepted tick, oldest first
	tick_t         on_bus;
	motor_result_t oldest;
	int            ticks_in_flight = 0;   // queued plus on the bus
	int            send_idle_pct   = 0;
	int            recv_idle_pct   = 0;
	int            mismatches      = 0;
	logic          hold_active     = 1'b0;
	event          stall_start;

	motion_command_sequencer_core dut (.*);

	always #1 clk = ~clk;

	function automatic logic signed [39:0] clamp40(input longint v);
		if (v > SAT_HI) return 40'(SAT_HI);
		if (v < SAT_LO) return 40'(SAT_LO);
		return 40'(v);
	endfunction

	// One tick of the sequencer: integrate yaw, pick the speed pair, grow the
	// distance counter from the previous speeds, then apply any command taken.
	function automatic motor_result_t advance_sequencer(input tick_t t);
		longint        rate, ms, batt, spd, a, b, yt, dt, inc;
		logic [3:0]    lim;
		logic [2:0]    op;
		motor_result_t r;
		rate = longint'(t.gyro) - longint'(cfg_gyro_offset);
		ms   = t.ms;
		batt = t.batt;
		spd  = cfg_drive_speed;
		yt   = cfg_yaw_thr;
		dt   = cfg_dist_thr;
		a    = 0;
		b    = 0;
		op   = CMD_STOP;
		yaw_acc = clamp40(yaw_acc + rate * ms);
		if (yaw_acc > yt || yaw_acc < -yt) begin
			r.action = ACT_TURN;
			if (yaw_acc < 0) begin
				a = spd;
				b = -spd;
			end else begin
				a = -spd;
				b = spd;
			end
		end else if (dist_acc > dt || dist_acc < -dt) begin
			r.action = ACT_DRIVE;
			if (dist_acc > 0) begin
				a = -spd;
				b = -spd;
			end else begin
				a = spd;
				b = spd;
			end
		end else begin
			// oversized counts act as the full list length of MAX_CMDS
			lim = (cfg_cmd_count > MAX_CMDS) ? 4'(MAX_CMDS) : cfg_cmd_count;
			if (cmd_ptr >= lim) begin
				r.action = ACT_DONE;
			end else begin
				r.action = ACT_NEXT;
				op       = cfg_cmd_list[cmd_ptr[2:0] * 3 +: 3];
				cmd_ptr  = cmd_ptr + 4'd1;
			end
		end
		// distance grows only while the previous pair was a straight drive (or a stop)
		if (last_a == last_b) begin
			inc      = ms * batt * longint'(last_a) / 1000;
			dist_acc = clamp40(dist_acc + inc);
		end
		case (op)
			CMD_FWD:   dist_acc = clamp40(dist_acc - longint'(cfg_step_dist));
			CMD_BACK:  dist_acc = clamp40(dist_acc + longint'(cfg_step_dist));
			CMD_RIGHT: yaw_acc  = clamp40(yaw_acc + QUARTER_TURN);
			CMD_LEFT:  yaw_acc  = clamp40(yaw_acc - QUARTER_TURN);
			default: ;
		endcase
		last_a        = 9'(a);
		last_b        = 9'(b);
		r.pwm_a       = 8'((a < 0) ? -a : a);
		r.reverse_a   = (a < 0);
		r.pwm_b       = 8'((b < 0) ? -b : b);
		r.reverse_b   = (b < 0);
		r.standby_on  = (a != 0 && b != 0);
		r.step_number = cmd_ptr;
		return r;
	endfunction

	// Mostly a plausible robot: when the heading is off, the gyro reports a
	// rate that brings yaw back toward zero; otherwise it shows small noise.
	// One tick in five is raw noise over the full field ranges.
	function automatic tick_t random_tick();
		tick_t  t;
		longint ms, corr, g, yt;
		ms     = ($urandom_range(99) < 3) ? 0 : $urandom_range(1023, 1);
		t.ms   = 10'(ms);
		t.batt = ($urandom_range(9) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(1023, 300));
		if ($urandom_range(99) < 20) begin
			t.gyro = 16'($urandom);
			t.ms   = 10'($urandom);
			t.batt = 10'($urandom);
			return t;
		end
		yt = cfg_yaw_thr;
		if ((yaw_acc > yt || yaw_acc < -yt) && ms != 0)
			corr = -(yaw_acc / (ms * longint'($urandom_range(4, 1))));
		else
			corr = longint'($urandom_range(80)) - 40;
		g = longint'(cfg_gyro_offset) + corr;
		if (g > 32767)
			g = 32767;
		if (g < -32768)
			g = -32768;
		t.gyro = 16'(g);
		return t;
	endfunction

	function automatic void compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Keep at most one tick waiting behind the one on the bus, so closed-loop
	// ticks are generated from nearly current predicted yaw.
	task automatic queue_tick(input bit randomize_it, input tick_t t);
		while (ticks_in_flight >= 2)
			@(posedge clk);
		if (randomize_it)
			t = random_tick();
		pending_ticks.push_back(t);
		ticks_in_flight++;
	endtask

	task automatic run_random(input int n);
		repeat (n) queue_tick(1'b1, '0);
	endtask

	// Wait for the block to go idle: every tick accepted and answered.
	task automatic settle();
		do @(posedge clk); while (ticks_in_flight != 0 || predicted_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Register write transaction; the predictor copy changes on acceptance.
	task automatic write_reg(input reg_idx_e idx, input logic [29:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_YAW_THR:   cfg_yaw_thr     = val;
			REG_DIST_THR:  cfg_dist_thr    = val;
			REG_STEP_DIST: cfg_step_dist   = val;
			REG_SPEED:     cfg_drive_speed = val[7:0];
			REG_GYRO_OFS:  cfg_gyro_offset = val[15:0];
			REG_CMD_LIST:  cfg_cmd_list    = val[23:0];
			REG_CMD_COUNT: cfg_cmd_count   = val[3:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// Tick driver: predicts on each accepted transaction, then offers the next
	// queued tick unless it rolls an idle cycle. valid holds until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predicted_results.push_back(advance_sequencer(on_bus));
				ticks_in_flight--;
			end
			if (!in_valid || in_ready) begin
				if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_bus = pending_ticks.pop_front();
					in_valid      <= 1'b1;
					gyro_z        <= on_bus.gyro;
					elapsed_ms    <= on_bus.ms;
					battery_level <= on_bus.batt;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each accepted transaction against the oldest
	// prediction and draws the next ready, forced low during a long stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: result with no tick outstanding: %h", $time,
						{pwm_a, reverse_a, pwm_b, reverse_b, standby_on, action, step_number});
					mismatches++;
				end else begin
					oldest = predicted_results.pop_front();
					compare_field("pwm_a", oldest.pwm_a, pwm_a);
					compare_field("reverse_a", oldest.reverse_a, reverse_a);
					compare_field("pwm_b", oldest.pwm_b, pwm_b);
					compare_field("reverse_b", oldest.reverse_b, reverse_b);
					compare_field("standby_on", oldest.standby_on, standby_on);
					compare_field("action", oldest.action, action);
					compare_field("step_number", oldest.step_number, step_number);
				end
			end
			out_ready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Long receiver hold-off; the sender keeps offering, so the block backs up
	always begin
		@(stall_start);
		@(posedge clk);
		hold_active <= 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	initial begin
		logic signed [15:0] ofs;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Phase 1: reset defaults, sender idles lightly, receiver heavily.
		send_idle_pct = 17;
		recv_idle_pct = 55;
		// directed: zero tick, full-scale rates both ways, alternating bit
		// patterns, zero battery and zero elapsed time
		queue_tick(1'b0, '{16'sd0, 10'd0, 10'd0});
		queue_tick(1'b0, '{16'sd32767, 10'd1023, 10'd1023});
		queue_tick(1'b0, '{-16'sd32768, 10'd1023, 10'd0});
		queue_tick(1'b0, '{16'sd0, 10'd1023, 10'd1023});
		queue_tick(1'b0, '{16'sd0, 10'd1023, 10'd1023});
		queue_tick(1'b0, '{16'sd1, 10'd1, 10'd1});
		queue_tick(1'b0, '{-16'sd1, 10'd1000, 10'd512});
		queue_tick(1'b0, '{16'sh5555, 10'h155, 10'h2aa});
		queue_tick(1'b0, '{16'shaaaa, 10'h2aa, 10'h155});
		queue_tick(1'b0, '{16'sd0, 10'd0, 10'd1023});
		queue_tick(1'b0, '{16'sd0, 10'd1023, 10'd0});
		queue_tick(1'b0, '{-16'sd32768, 10'd1023, 10'd1023});
		queue_tick(1'b0, '{-16'sd32768, 10'd1023, 10'd1023});
		queue_tick(1'b0, '{16'sd32767, 10'd1023, 10'd1023});
		queue_tick(1'b0, '{16'sd32767, 10'd1023, 10'd1023});
		queue_tick(1'b0, '{16'sd0, 10'd512, 10'd1023});
		queue_tick(1'b0, '{16'sd0, 10'd1023, 10'd1023});
		queue_tick(1'b0, '{16'sd0, 10'd1023, 10'd1023});
		run_random(480);
		settle();

		// Phase 2: roles swapped. List entries 4 and 5 are an unused code then back;
		// zero distance threshold keeps the robot hunting around the target.
		send_idle_pct = 55;
		recv_idle_pct = 17;
		ofs = 16'($urandom_range(4000));
		ofs = ofs - 16'sd2000;
		write_reg(REG_YAW_THR, 30'd1000000);
		write_reg(REG_DIST_THR, 30'd0);
		write_reg(REG_STEP_DIST, 30'd3000000);
		write_reg(REG_SPEED, 30'd255);
		write_reg(REG_GYRO_OFS, {14'd0, ofs});
		write_reg(REG_CMD_LIST, {12'd0, 3'(CMD_BACK), 3'($urandom_range(7, 5)), 12'($urandom)});
		write_reg(REG_CMD_COUNT, 30'd15);
		run_random(100);
		-> stall_start;
		run_random(450);
		settle();

		// Phase 3a: no idling; zero yaw threshold and zero speed, offset extremes.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_YAW_THR, 30'd0);
		write_reg(REG_DIST_THR, 30'h3fffffff);
		write_reg(REG_STEP_DIST, 30'h3fffffff);
		write_reg(REG_SPEED, 30'd0);
		write_reg(REG_GYRO_OFS, 30'h7fff);
		write_reg(REG_CMD_LIST, 30'd0);
		write_reg(REG_CMD_COUNT, 30'd0);
		run_random(125);
		settle();
		write_reg(REG_GYRO_OFS, 30'h8000);
		run_random(125);
		settle();

		// Phase 3b: list exhausted, random speed, tight distance threshold.
		ofs = 16'($urandom_range(2000));
		ofs = ofs - 16'sd1000;
		write_reg(REG_YAW_THR, 30'd200000);
		write_reg(REG_DIST_THR, 30'd0);
		write_reg(REG_STEP_DIST, 30'($urandom));
		write_reg(REG_SPEED, 30'($urandom_range(255, 1)));
		write_reg(REG_GYRO_OFS, {14'd0, ofs});
		write_reg(REG_CMD_LIST, 30'hffffff);
		write_reg(REG_CMD_COUNT, 30'(MAX_CMDS));
		run_random(350);
		settle();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_motion_command_sequencer_core: clean");
		else
			$display("tb_motion_command_sequencer_core: errors");
		$finish;
	end

	// Run limit, far beyond the slowest correct run
	initial begin
		#4000000;
		$display("tb_motion_command_sequencer_core: errors");
		$finish;
	end

endmodule
